/* rtl/rhc_pkg.sv */
// Package for the RGB to HSV/HSL converter: widths, defaults and shared types.
// Used by every module under rtl.
package rhc_pkg;
  localparam int unsigned CHANNEL_BITS_DEF  = 8;
  localparam int unsigned FRACTION_BITS_DEF = 12;
  localparam int unsigned HUE_BITS          = 12;
  localparam int unsigned HUE_FULL          = 3600;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2,
    SECT_GREY  = 2'd3
  } sector_e;
endpackage

/* rtl/rgb_to_hsv_hsl_converter.sv */
// RGB to HSV/HSL converter top level; depends on rhc_pkg, rhc_front, rhc_queue, rhc_back.
// done rises once the word has passed the front register, queue slot, NB divider stages
// and output register, NB = CHANNEL_BITS + max(FRACTION_BITS + 1, 13). Throughput one word
// per cycle; busy stays low, dividers are fully pipelined. The receiver cannot stall; each
// result shows for one cycle with done_o.
// Reset clears all valid flags and color_space to HSV; payload registers are not reset.
module rgb_to_hsv_hsl_converter #(
  parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [CHANNEL_BITS-1:0]   red_i,
  input  logic [CHANNEL_BITS-1:0]   green_i,
  input  logic [CHANNEL_BITS-1:0]   blue_i,
  input  logic [CHANNEL_BITS-1:0]   alpha_i,
  output logic                      done_o,
  output logic [rhc_pkg::HUE_BITS-1:0] hue_o,
  output logic [FRACTION_BITS-1:0]  saturation_o,
  output logic [FRACTION_BITS-1:0]  level_o,
  output logic [CHANNEL_BITS-1:0]   alpha_out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i
);
  import rhc_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned QW = (CB + 13) + CB + (CB + FB + 1) + CB + (CB + FB + 2) + 2 + CB;

  logic hsl_q;
  logic fv;
  logic [CB+12:0] hnum;
  logic [CB-1:0] hden, sden, alpha_f;
  logic [CB+FB:0] snum;
  logic [CB+FB+1:0] lnum;
  logic grey, szero;
  logic qv;
  logic [QW-1:0] qd;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // hold the color space select; the user writes it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsl_q <= 1'b0;
    end else if (cfg_valid_i) begin
      hsl_q <= cfg_data_i;
    end
  end

  rhc_front #(.CHANNEL_BITS(CB), .FRACTION_BITS(FB)) u_front (
    .clk_i, .rst_ni, .valid_i(start), .hsl_i(hsl_q),
    .red_i, .green_i, .blue_i, .alpha_i,
    .valid_o(fv), .hnum_o(hnum), .hden_o(hden), .snum_o(snum), .sden_o(sden),
    .lnum_o(lnum), .grey_o(grey), .szero_o(szero), .alpha_o(alpha_f)
  );

  rhc_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(fv),
    .data_i({hnum, hden, snum, sden, lnum, grey, szero, alpha_f}),
    .valid_o(qv), .data_o(qd)
  );

  rhc_back #(.CHANNEL_BITS(CB), .FRACTION_BITS(FB)) u_back (
    .clk_i, .rst_ni, .valid_i(qv),
    .hnum_i(qd[QW-1 -: CB+13]),
    .hden_i(qd[QW-CB-14 -: CB]),
    .snum_i(qd[QW-2*CB-14 -: CB+FB+1]),
    .sden_i(qd[QW-3*CB-FB-15 -: CB]),
    .lnum_i(qd[CB+2 +: CB+FB+2]),
    .grey_i(qd[CB+1]), .szero_i(qd[CB]), .alpha_i(qd[CB-1:0]),
    .valid_o(done_o), .hue_o, .saturation_o, .level_o, .alpha_o(alpha_out_o)
  );
endmodule

/* rtl/rhc_divider.sv */
// Pipelined restoring divider: one numerator bit per stage, registered after each stage.
// Depends on rhc_pkg (import only). A new division enters every cycle.
module rhc_divider #(
  parameter int unsigned NBITS = 32,
  parameter int unsigned DBITS = 16,
  parameter int unsigned QBITS = 16,
  parameter int unsigned TBITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NBITS-1:0] num_i,
  input  logic [DBITS-1:0] den_i,
  input  logic [TBITS-1:0] tag_i,
  output logic             valid_o,
  output logic [QBITS-1:0] quo_o,
  output logic [TBITS-1:0] tag_o
);
  import rhc_pkg::*;

  localparam int unsigned RBITS = DBITS + 1;

  // stage s holds the state after numerator bit NBITS-1-s
  logic             vld_q [NBITS];
  logic [QBITS-1:0] quo_q [NBITS];
  logic [TBITS-1:0] tag_q [NBITS];
  logic [NBITS-1:0] num_q [NBITS-1];
  logic [DBITS-1:0] den_q [NBITS-1];
  logic [DBITS-1:0] rem_q [NBITS-1];

  for (genvar s = 0; s < NBITS; s++) begin : g_stage
    logic             vld_in;
    logic [NBITS-1:0] num_in;
    logic [DBITS-1:0] rem_in;
    logic [DBITS-1:0] den_in;
    logic [QBITS-1:0] quo_in;
    logic [TBITS-1:0] tag_in;
    logic [RBITS-1:0] shifted;
    logic [RBITS:0]   diff;
    logic             take;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_comb begin
      shifted = {rem_in, num_in[NBITS-1-s]};
      diff    = {1'b0, shifted} - {2'b00, den_in};
      take    = !diff[RBITS];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= {quo_in[QBITS-2:0], take};
      tag_q[s] <= tag_in;
    end

    if (s < NBITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        num_q[s] <= num_in;
        den_q[s] <= den_in;
        rem_q[s] <= take ? diff[DBITS-1:0] : shifted[DBITS-1:0];
      end
    end
  end

  assign valid_o = vld_q[NBITS-1];
  assign quo_o   = quo_q[NBITS-1];
  assign tag_o   = tag_q[NBITS-1];
endmodule

/* rtl/rhc_front.sv */
// Front end: finds max, min and d, picks the hue sector and forms the divider operands and level numerator.
// Depends on rhc_pkg. One registered stage; takes a word every cycle.
module rhc_front #(
  parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       hsl_i,
  input  logic [CHANNEL_BITS-1:0]    red_i,
  input  logic [CHANNEL_BITS-1:0]    green_i,
  input  logic [CHANNEL_BITS-1:0]    blue_i,
  input  logic [CHANNEL_BITS-1:0]    alpha_i,
  output logic                       valid_o,
  output logic [CHANNEL_BITS+12:0]   hnum_o,
  output logic [CHANNEL_BITS-1:0]    hden_o,
  output logic [CHANNEL_BITS+FRACTION_BITS:0] snum_o,
  output logic [CHANNEL_BITS-1:0]    sden_o,
  output logic [CHANNEL_BITS+FRACTION_BITS+1:0] lnum_o,
  output logic                       grey_o,
  output logic                       szero_o,
  output logic [CHANNEL_BITS-1:0]    alpha_o
);
  import rhc_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned HB = CB + 13;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [FB-1:0] FMAX = {FB{1'b1}};

  logic [CB-1:0] mx, mn, d, sden;
  logic [CB:0]   sum, off;
  sector_e       sect;
  logic [HB-1:0] t, num_h;
  logic [CB+FB-1:0] prod_s;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    off = (sum >= {1'b0, CMAX}) ? sum - {1'b0, CMAX} : {1'b0, CMAX} - sum;
    if (d == '0) sect = SECT_GREY;
    else if (mx == red_i) sect = SECT_RED;
    else if (mx == green_i) sect = SECT_GREEN;
    else sect = SECT_BLUE;
    // hue numerator, in tenths times d, always non-negative
    unique case (sect)
      SECT_RED: begin
        if (green_i >= blue_i) t = HB'(600) * HB'(green_i - blue_i);
        else t = HB'(3600) * HB'(d) - HB'(600) * HB'(blue_i - green_i);
      end
      SECT_GREEN: t = HB'(1200) * HB'(d) + HB'(600) * HB'(blue_i) - HB'(600) * HB'(red_i);
      SECT_BLUE:  t = HB'(2400) * HB'(d) + HB'(600) * HB'(red_i) - HB'(600) * HB'(green_i);
      default:    t = '0;
    endcase
    // round to nearest: (2t + d) / 2d
    num_h  = {t[HB-2:0], 1'b0} + HB'(d);
    prod_s = (CB+FB)'(d) * (CB+FB)'(FMAX);
    sden   = hsl_i ? CB'(CMAX - off[CB-1:0]) : mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hnum_o  <= num_h;
    hden_o  <= (d == '0) ? CB'(1) : d;
    snum_o  <= {prod_s, 1'b0} + (CB+FB+1)'(sden);
    sden_o  <= (sden == '0) ? CB'(1) : sden;
    grey_o  <= (d == '0);
    szero_o <= (sden == '0);
    // level: HSV max*FMAX/CMAX, HSL sum*FMAX/(2*CMAX); as num over 4*CMAX with rounding
    lnum_o  <= hsl_i ?
      (CB+FB+2)'(2) * ((CB+FB+2)'(sum) * (CB+FB+2)'(FMAX)) + (CB+FB+2)'(2) * (CB+FB+2)'(CMAX)
      : (CB+FB+2)'(4) * ((CB+FB+2)'(mx) * (CB+FB+2)'(FMAX)) + (CB+FB+2)'(2) * (CB+FB+2)'(CMAX);
    alpha_o <= alpha_i;
  end
endmodule

/* rtl/rhc_queue.sv */
// Short word queue between front and back end; fall-through free, registered storage.
// Depends on rhc_pkg for the depth constant.
module rhc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import rhc_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  // back end never stalls: drain one word each cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (cnt_q != '0) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(cnt_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
endmodule

/* rtl/rhc_back.sv */
// Back end: two pipelined dividers for hue and saturation, level by reciprocal multiply.
// Depends on rhc_pkg and rhc_divider.
module rhc_back #(
  parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [CHANNEL_BITS+12:0]   hnum_i,
  input  logic [CHANNEL_BITS-1:0]    hden_i,
  input  logic [CHANNEL_BITS+FRACTION_BITS:0] snum_i,
  input  logic [CHANNEL_BITS-1:0]    sden_i,
  input  logic [CHANNEL_BITS+FRACTION_BITS+1:0] lnum_i,
  input  logic                       grey_i,
  input  logic                       szero_i,
  input  logic [CHANNEL_BITS-1:0]    alpha_i,
  output logic                       valid_o,
  output logic [rhc_pkg::HUE_BITS-1:0] hue_o,
  output logic [FRACTION_BITS-1:0]   saturation_o,
  output logic [FRACTION_BITS-1:0]   level_o,
  output logic [CHANNEL_BITS-1:0]    alpha_o
);
  import rhc_pkg::*;

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned QB  = (FB > HUE_BITS ? FB : HUE_BITS) + 1;
  localparam int unsigned HNB = CB + 13;
  localparam int unsigned SNB = CB + FB + 1;
  localparam int unsigned NB  = (HNB > SNB) ? HNB : SNB;
  localparam int unsigned TB  = 1 + FB + CB;
  localparam int unsigned LB  = CB + FB + 2;
  localparam int unsigned LS  = LB + CB + 2;
  // level divides by 4*CMAX; exact for any LB-bit numerator with this reciprocal
  localparam logic [63:0] LDIV = 64'(4) * ((64'(1) << CB) - 64'(1));
  localparam logic [63:0] LREC = ((64'(1) << LS) + LDIV - 64'(1)) / LDIV;

  logic [QB-1:0]   qh, qs;
  logic [TB-1:0]   th;
  logic            ts;
  logic            vh, vs;
  logic [2*LB:0]   lprod;
  logic [FB-1:0]   lev;

  always_comb begin
    lprod = (2*LB+1)'(lnum_i) * (2*LB+1)'(LREC[LB:0]);
    lev   = lprod[LS +: FB];
  end

  // both dividers share latency; quotients sized to cover 2x rounding headroom
  rhc_divider #(.NBITS(NB), .DBITS(CB + 1), .QBITS(QB), .TBITS(TB)) u_hdiv (
    .clk_i, .rst_ni, .valid_i,
    .num_i(NB'(hnum_i)), .den_i({hden_i, 1'b0}), .tag_i({grey_i, lev, alpha_i}),
    .valid_o(vh), .quo_o(qh), .tag_o(th)
  );
  rhc_divider #(.NBITS(NB), .DBITS(CB + 1), .QBITS(QB), .TBITS(1)) u_sdiv (
    .clk_i, .rst_ni, .valid_i,
    .num_i(NB'(snum_i)), .den_i({sden_i, 1'b0}), .tag_i(szero_i),
    .valid_o(vs), .quo_o(qs), .tag_o(ts)
  );

  logic [QB-1:0] hw;
  always_comb begin
    hw = (qh >= QB'(HUE_FULL)) ? qh - QB'(HUE_FULL) : qh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vh & vs;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o        <= th[TB-1] ? '0 : hw[HUE_BITS-1:0];
    saturation_o <= (th[TB-1] | ts) ? '0 : qs[FB-1:0];
    level_o      <= th[CB +: FB];
    alpha_o      <= th[CB-1:0];
  end
endmodule

/* verif/rgb_to_hsv_hsl_converter_test.sv */
// Self-checking testbench for rgb_to_hsv_hsl_converter: random and directed pixels
// in HSV and HSL modes, checked against an in-bench predictor. Depends on rhc_pkg.
`timescale 1ns / 100ps

module rgb_to_hsv_hsl_converter_test;
  import rhc_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS_DEF;
  localparam int unsigned FB = FRACTION_BITS_DEF;
  localparam int CHAN_FULL = (1 << CB) - 1;
  localparam int FRAC_FULL = (1 << FB) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  // Color space codes of the one register.
  localparam logic SPACE_HSV = 1'b0;
  localparam logic SPACE_HSL = 1'b1;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic [CB-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [FB-1:0]       sat;
    logic [FB-1:0]       lev;
    logic [CB-1:0]       alpha;
  } color_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic [CB-1:0] red_i, green_i, blue_i, alpha_i;
  logic          done_o;
  logic [HUE_BITS-1:0] hue_o;
  logic [FB-1:0] saturation_o, level_o;
  logic [CB-1:0] alpha_out_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic          cfg_data_i;

  pixel_t pixel_q[$];    // pixels waiting to be driven
  color_t color_q[$];    // predicted conversions, oldest first
  logic   space_model;   // testbench copy of color_space
  bit     calm;          // no idling in the last phase
  int     gap_left;
  int     fail_count;
  int     cycle_count;

  rgb_to_hsv_hsl_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .done_o       (done_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .level_o      (level_o),
    .alpha_out_o  (alpha_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round num/den to nearest, ties up.
  function automatic int round_div(int num, int den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Convert one pixel under the given color space.
  function automatic color_t convert_pixel(pixel_t px, logic space);
    color_t c;
    int r, g, b, mx, mn, d, t, h, sum, off, den;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // Hue: red sector wins ties, then green; wrap negatives and a full circle.
    if (d == 0) begin
      h = 0;
    end else begin
      if (mx == r) begin
        t = 600 * (g - b);
        if (t < 0) t += 3600 * d;
      end else if (mx == g) begin
        t = 600 * (b - r) + 1200 * d;
      end else begin
        t = 600 * (r - g) + 2400 * d;
      end
      h = round_div(t, d);
      if (h >= HUE_FULL) h -= HUE_FULL;
    end
    c.hue = h[HUE_BITS-1:0];
    if (space == SPACE_HSV) begin
      c.sat = (mx > 0) ? FB'(round_div(d * FRAC_FULL, mx)) : '0;
      c.lev = FB'(round_div(mx * FRAC_FULL, CHAN_FULL));
    end else begin
      sum = mx + mn;
      off = sum - CHAN_FULL;
      if (off < 0) off = -off;
      den = CHAN_FULL - off;
      if (d == 0) c.sat = '0;
      else if (den <= 0) c.sat = FB'(FRAC_FULL);
      else c.sat = FB'(round_div(d * FRAC_FULL, den));
      c.lev = FB'(round_div(sum * FRAC_FULL, 2 * CHAN_FULL));
    end
    c.alpha = px.alpha;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Driver: advance to the next pixel once the current word is taken,
  // or hold start low for a random idle burst.
  bit took;
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 18);
        start <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel_t px;
        px = pixel_q.pop_front();
        red_i   <= px.red;
        green_i <= px.green;
        blue_i  <= px.blue;
        alpha_i <= px.alpha;
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted word, check every strobed result.
  always @(posedge clk_i) begin
    color_t want;
    took = start && !busy && rst_ni;
    if (took)
      color_q.push_back(convert_pixel({red_i, green_i, blue_i, alpha_i}, space_model));
    if (rst_ni && done_o) begin
      if (color_q.size() == 0) begin
        $display("unexpected result at %0t: hue %0d", $realtime, hue_o);
        fail_count++;
      end else begin
        want = color_q.pop_front();
        if (hue_o !== want.hue) report_mismatch("hue", hue_o, want.hue);
        if (saturation_o !== want.sat) report_mismatch("saturation", saturation_o, want.sat);
        if (level_o !== want.lev) report_mismatch("level", level_o, want.lev);
        if (alpha_out_o !== want.alpha) report_mismatch("alpha", alpha_out_o, want.alpha);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_pixel(int r, int g, int b, int a);
    pixel_q.push_back({CB'(r), CB'(g), CB'(b), CB'(a)});
  endtask

  // Wait until the pipe is empty; write_space then writes color_space through its channel.
  task automatic drain();
    while (pixel_q.size() > 0 || start || color_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_space(logic space);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= space;
    do @(posedge clk_i); while (!cfg_ready_o);
    space_model = space;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Corner pixels: extremes, each hue sector, ties between channels, grey,
  // black, and the red sector with a negative raw hue.
  task automatic add_corners();
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 255, 255, 255);
    add_pixel(128, 128, 128, 1);
    add_pixel(255, 0, 0, 128);
    add_pixel(0, 255, 0, 127);
    add_pixel(0, 0, 255, 85);
    add_pixel(255, 255, 0, 170);
    add_pixel(0, 255, 255, 240);
    add_pixel(255, 0, 255, 15);
    add_pixel(255, 0, 1, 2);
    add_pixel(255, 1, 0, 4);
    add_pixel(1, 0, 0, 8);
    add_pixel(0, 0, 1, 16);
    add_pixel(254, 255, 255, 32);
    add_pixel(255, 254, 254, 64);
    add_pixel(1, 1, 2, 200);
    add_pixel(200, 100, 100, 99);
    add_pixel(128, 127, 255, 254);
  endtask

  task automatic add_random(int count);
    int m, v;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          v = $urandom_range(0, 255);
          add_pixel(v, v, v, $urandom_range(0, 255));
        end
        1: begin
          // two channels tie for the maximum
          m = $urandom_range(0, 255);
          v = $urandom_range(0, m);
          case ($urandom_range(0, 2))
            0: add_pixel(m, m, v, $urandom_range(0, 255));
            1: add_pixel(v, m, m, $urandom_range(0, 255));
            default: add_pixel(m, v, m, $urandom_range(0, 255));
          endcase
        end
        default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    alpha_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    space_model = SPACE_HSV;
    calm        = 1'b0;
    gap_left    = 0;
    fail_count  = 0;
    cycle_count = 0;
    took        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // HSV straight after reset, then HSL, then back, then HSL with no idling.
    add_corners();
    add_random(320);
    write_space(SPACE_HSL);
    add_corners();
    add_random(320);
    write_space(SPACE_HSV);
    add_random(330);
    write_space(SPACE_HSL);
    calm = 1'b1;
    add_random(330);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
